### rtl/core/cpc_pkg.sv
// shared types, constants and the arctangent table of the coordinate converter
`default_nettype none

package cpc_pkg;

    // command codes carried in tuser
    localparam logic CMD_TO_POLAR = 1'b0;
    localparam logic CMD_TO_CART  = 1'b1;

    // field widths
    localparam int IN_W      = 16;
    localparam int OUT_A_W   = 17;
    localparam int OUT_B_W   = 16;
    localparam int S_TDATA_W = 2 * IN_W;
    localparam int M_TDATA_W = 40;
    localparam int PAD_W     = M_TDATA_W - OUT_A_W - OUT_B_W;

    // fixed point formats
    localparam int FRAC      = 16;
    localparam int ANG_SHIFT = FRAC - 7;
    localparam int XY_W      = 36;
    localparam int Z_W       = 27;
    localparam int MUL_W     = 49;
    localparam int MAG_W     = 34;
    localparam int LO_W      = 17;
    localparam int PSUM_W    = 67;
    localparam int MAG_RES_W = PSUM_W - FRAC - 32;
    localparam int XR_W      = 21;
    localparam int ANG_W     = 18;
    localparam int CLAMP_W   = 34;

    // angle constants, degrees
    localparam int DEG180    = 180 * (2 ** FRAC);
    localparam int ANG_MAX   = 23040;
    localparam int FULL_TURN = 46080;
    localparam int A_FOLD    = 11520;
    localparam int HALF_FRAC = 2 ** (FRAC - 1);
    localparam int HALF_ANG  = 2 ** (ANG_SHIFT - 1);

    // reciprocal of the cordic gain, scaled by 2^32
    localparam logic [31:0] GAIN_K = 32'd2608131496;

    // one word in flight through the rotation stages
    typedef struct packed {
        logic                   polar;
        logic                   zero;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    // atan(2^-i) in degrees scaled by 2^16
    function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
        case (idx)
            0:       return 27'sd2949120;
            1:       return 27'sd1740967;
            2:       return 27'sd919879;
            3:       return 27'sd466945;
            4:       return 27'sd234379;
            5:       return 27'sd117304;
            6:       return 27'sd58666;
            7:       return 27'sd29335;
            8:       return 27'sd14668;
            9:       return 27'sd7334;
            10:      return 27'sd3667;
            11:      return 27'sd1833;
            12:      return 27'sd917;
            13:      return 27'sd458;
            14:      return 27'sd229;
            15:      return 27'sd115;
            16:      return 27'sd57;
            17:      return 27'sd29;
            18:      return 27'sd14;
            19:      return 27'sd7;
            20:      return 27'sd4;
            21:      return 27'sd2;
            22:      return 27'sd1;
            default: return 27'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

### rtl/core/cpc_stage.sv
// one registered cordic micro-rotation stage
`default_nettype none

module cpc_stage #(
    parameter int IDX = 0
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            adv,
    input  wire logic            in_valid,
    input  wire cpc_pkg::cordic_t in_data,
    output logic                 out_valid,
    output cpc_pkg::cordic_t     out_data
);
    import cpc_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_deg(IDX);

    logic                   valid_reg;
    cordic_t                data_reg;
    cordic_t                data_next;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    logic                   rot_pos;

    // shifted cross terms and rotation sense
    assign dx      = in_data.y >>> IDX;
    assign dy      = in_data.x >>> IDX;
    assign rot_pos = in_data.polar ? in_data.y[XY_W-1] : !in_data.z[Z_W-1];

    // micro-rotation
    always_comb begin
        data_next = in_data;
        if (rot_pos) begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN;
        end else begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN;
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

### rtl/core/cartesian_polar_converter.sv
// top level of the pipelined cordic cartesian/polar converter
//
// The s_ channel takes one word per cycle while s_tready is high: s_tuser selects the direction
// (0 to polar, 1 to cartesian), s_tdata carries in_a and in_b. The m_
// channel returns one word per input word, in order, with out_a and out_b
// packed in m_tdata.
// Throughput is one word per clock while m_tready stays high. Before it shows
// on m_tvalid, a word passes one input stage holding the gain multiply,
// one fold stage, one register stage per micro-rotation and one stage for
// the gain multiply of the magnitude, then the output register.
// When the receiver stalls, the next finished word parks in a skid register
// and the whole pipeline holds; s_tready drops only while that skid register
// is full, and returns the cycle after the receiver takes a word.
// Reset (aresetn low, synchronous) empties every stage, the output and the
// skid register; words in flight are dropped.
`default_nettype none

module cartesian_polar_converter #(
    parameter int ITERATIONS  = 16,
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // in_a [15:0], in_b [31:16]
    input  wire logic [cpc_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd [0]
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // out_a [16:0], out_b [32:17], zero fill [39:33]
    output logic [cpc_pkg::M_TDATA_W-1:0]      m_tdata
);
    import cpc_pkg::*;

    localparam int RES_W = OUT_A_W + OUT_B_W;
    localparam logic [CLAMP_W-1:0] MAG_MAX =
        ({{(CLAMP_W-1){1'b0}}, 1'b1} << COORD_WIDTH) - {{(CLAMP_W-1){1'b0}}, 1'b1};
    localparam logic signed [CLAMP_W-1:0] LIM   = CLAMP_W'(1) <<< (COORD_WIDTH - 1);
    localparam logic signed [CLAMP_W-1:0] NLIM  = -LIM;
    localparam logic signed [CLAMP_W-1:0] LIM_Y = LIM - CLAMP_W'(1);

    logic adv;

    // input fields
    logic signed [IN_W-1:0] in_a;
    logic signed [IN_W-1:0] in_b;
    assign in_a = s_tdata[IN_W-1:0];
    assign in_b = s_tdata[S_TDATA_W-1:IN_W];

    // ---------------- stage 0: polar prerotation, gain multiply ----------------
    cordic_t                 pol_next;
    logic signed [XY_W-1:0]  xa;
    logic signed [XY_W-1:0]  ya;
    logic signed [IN_W:0]    ang_wrap;
    logic signed [IN_W-1:0]  ang_next;
    logic signed [MUL_W-1:0] prod_next;

    logic                    s0_valid_reg;
    cordic_t                 s0_pol_reg;
    logic signed [IN_W-1:0]  s0_ang_reg;
    logic signed [MUL_W-1:0] s0_prod_reg;

    assign xa = XY_W'(in_a) <<< FRAC;
    assign ya = XY_W'(in_b) <<< FRAC;

    // left half plane turns by 180 degrees
    always_comb begin
        pol_next.polar = (s_tuser == CMD_TO_POLAR);
        pol_next.zero  = (in_a == 0) && (in_b == 0);
        if (in_a < 0) begin
            pol_next.x = -xa;
            pol_next.y = -ya;
            pol_next.z = (in_b >= 0) ? Z_W'(DEG180) : -Z_W'(DEG180);
        end else begin
            pol_next.x = xa;
            pol_next.y = ya;
            pol_next.z = '0;
        end
    end

    // out of range angle wraps by a full turn
    always_comb begin
        if (in_b > 16'(ANG_MAX)) begin
            ang_wrap = 17'(in_b) - 17'(FULL_TURN);
        end else if (in_b < -16'(ANG_MAX)) begin
            ang_wrap = 17'(in_b) + 17'(FULL_TURN);
        end else begin
            ang_wrap = 17'(in_b);
        end
        ang_next = ang_wrap[IN_W-1:0];
    end

    // magnitude times gain correction
    assign prod_next = MUL_W'(in_a) * MUL_W'($signed({1'b0, GAIN_K}));

    // ---------------- stage 1: cartesian rounding and quadrant fold ----------------
    cordic_t                 cart_next;
    cordic_t                 s1_next;
    logic signed [MUL_W-1:0] prod_sum;
    logic signed [MUL_W-1:0] prod_rnd;
    logic signed [XY_W-1:0]  x_start;
    logic                    fold_hi;
    logic                    fold_lo;
    logic signed [Z_W-1:0]   z_start;

    logic                    s1_valid_reg;
    cordic_t                 s1_data_reg;

    assign prod_sum = s0_prod_reg + MUL_W'(HALF_FRAC)
                    - {{(MUL_W-1){1'b0}}, s0_prod_reg[MUL_W-1]};
    assign prod_rnd = prod_sum >>> FRAC;
    assign x_start  = prod_rnd[XY_W-1:0];
    assign fold_hi  = s0_ang_reg > 16'(A_FOLD);
    assign fold_lo  = s0_ang_reg < -16'(A_FOLD);
    assign z_start  = Z_W'(s0_ang_reg) <<< ANG_SHIFT;

    // angles beyond 90 degrees start from the negated vector
    always_comb begin
        cart_next.polar = 1'b0;
        cart_next.zero  = 1'b0;
        cart_next.y     = '0;
        cart_next.x     = (fold_hi || fold_lo) ? -x_start : x_start;
        if (fold_hi) begin
            cart_next.z = z_start - Z_W'(DEG180);
        end else if (fold_lo) begin
            cart_next.z = z_start + Z_W'(DEG180);
        end else begin
            cart_next.z = z_start;
        end
        s1_next = s0_pol_reg.polar ? s0_pol_reg : cart_next;
    end

    // ---------------- rotation stages ----------------
    cordic_t stage_data  [0:ITERATIONS];
    logic    stage_valid [0:ITERATIONS];

    assign stage_data[0]  = s1_data_reg;
    assign stage_valid[0] = s1_valid_reg;

    for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
        cpc_stage #(
            .IDX (g)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (stage_valid[g]),
            .in_data   (stage_data[g]),
            .out_valid (stage_valid[g+1]),
            .out_data  (stage_data[g+1])
        );
    end

    // ---------------- post stage: gain partial products and rounding ----------------
    cordic_t                 last;
    logic [MAG_W-1:0]        xm;
    logic [MUL_W-1:0]        pp_lo_next;
    logic [MUL_W-1:0]        pp_hi_next;
    logic signed [Z_W-1:0]   z_sum;
    logic signed [Z_W-1:0]   z_rnd;
    logic signed [XY_W-1:0]  x_sum;
    logic signed [XY_W-1:0]  x_rnd;
    logic signed [XY_W-1:0]  y_sum;
    logic signed [XY_W-1:0]  y_rnd;

    logic                    p0_valid_reg;
    logic                    p0_polar_reg;
    logic                    p0_zero_reg;
    logic [MUL_W-1:0]        p0_pp_lo_reg;
    logic [MUL_W-1:0]        p0_pp_hi_reg;
    logic signed [ANG_W-1:0] p0_ang_reg;
    logic signed [XR_W-1:0]  p0_x_reg;
    logic signed [XR_W-1:0]  p0_y_reg;

    assign last       = stage_data[ITERATIONS];
    assign xm         = last.x[MAG_W-1:0];
    assign pp_lo_next = MUL_W'(xm[LO_W-1:0]) * MUL_W'(GAIN_K);
    assign pp_hi_next = MUL_W'(xm[MAG_W-1:LO_W]) * MUL_W'(GAIN_K);

    // round to nearest, ties away from zero
    assign z_sum = last.z + Z_W'(HALF_ANG) - {{(Z_W-1){1'b0}}, last.z[Z_W-1]};
    assign z_rnd = z_sum >>> ANG_SHIFT;
    assign x_sum = last.x + XY_W'(HALF_FRAC) - {{(XY_W-1){1'b0}}, last.x[XY_W-1]};
    assign x_rnd = x_sum >>> FRAC;
    assign y_sum = last.y + XY_W'(HALF_FRAC) - {{(XY_W-1){1'b0}}, last.y[XY_W-1]};
    assign y_rnd = y_sum >>> FRAC;

    // ---------------- result: magnitude sum, clamps ----------------
    logic [PSUM_W-1:0]        psum;
    logic [MAG_RES_W-1:0]     mag;
    logic [OUT_A_W-1:0]       mag_c;
    logic [OUT_B_W-1:0]       ang_c;
    logic signed [CLAMP_W-1:0] xe;
    logic signed [CLAMP_W-1:0] ye;
    logic [OUT_A_W-1:0]       xc;
    logic [OUT_B_W-1:0]       yc;
    logic [RES_W-1:0]         res;

    assign psum = PSUM_W'({p0_pp_hi_reg, {LO_W{1'b0}}}) + PSUM_W'(p0_pp_lo_reg)
                + (PSUM_W'(1) << (FRAC + 31));
    assign mag  = psum[PSUM_W-1:FRAC+32];
    assign xe   = CLAMP_W'(p0_x_reg);
    assign ye   = CLAMP_W'(p0_y_reg);

    always_comb begin
        // magnitude clamp, origin gives zero
        if (p0_zero_reg) begin
            mag_c = '0;
        end else if (CLAMP_W'(mag) > MAG_MAX) begin
            mag_c = MAG_MAX[OUT_A_W-1:0];
        end else begin
            mag_c = mag[OUT_A_W-1:0];
        end
        // angle clamp
        if (p0_zero_reg) begin
            ang_c = '0;
        end else if (p0_ang_reg > 18'(ANG_MAX)) begin
            ang_c = 16'(ANG_MAX);
        end else if (p0_ang_reg < -18'(ANG_MAX)) begin
            ang_c = -16'(ANG_MAX);
        end else begin
            ang_c = p0_ang_reg[OUT_B_W-1:0];
        end
        // cartesian clamps
        if (xe > LIM) begin
            xc = LIM[OUT_A_W-1:0];
        end else if (xe < NLIM) begin
            xc = NLIM[OUT_A_W-1:0];
        end else begin
            xc = xe[OUT_A_W-1:0];
        end
        if (ye > LIM_Y) begin
            yc = LIM_Y[OUT_B_W-1:0];
        end else if (ye < NLIM) begin
            yc = NLIM[OUT_B_W-1:0];
        end else begin
            yc = ye[OUT_B_W-1:0];
        end
        res = p0_polar_reg ? {ang_c, mag_c} : {yc, xc};
    end

    // ---------------- pipeline registers ----------------
    // valid bits move together while the skid register is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            p0_valid_reg <= 1'b0;
        end else if (adv) begin
            s0_valid_reg <= s_tvalid;
            s1_valid_reg <= s0_valid_reg;
            p0_valid_reg <= stage_valid[ITERATIONS];
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_pol_reg   <= pol_next;
            s0_ang_reg   <= ang_next;
            s0_prod_reg  <= prod_next;
            s1_data_reg  <= s1_next;
            p0_polar_reg <= last.polar;
            p0_zero_reg  <= last.zero;
            p0_pp_lo_reg <= pp_lo_next;
            p0_pp_hi_reg <= pp_hi_next;
            p0_ang_reg   <= z_rnd[ANG_W-1:0];
            p0_x_reg     <= x_rnd[XR_W-1:0];
            p0_y_reg     <= y_rnd[XR_W-1:0];
        end
    end

    // ---------------- output register and skid ----------------
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [RES_W-1:0] out_data_reg;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic [RES_W-1:0] skid_data_reg;
    logic             take;
    logic             arrive;
    logic             out_load;
    logic             out_from_skid;
    logic             skid_load;

    assign adv    = !skid_valid_reg;
    assign take   = out_valid_reg && m_tready;
    assign arrive = adv && p0_valid_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load        = 1'b0;
        out_from_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg) begin
            if (take) begin
                out_load        = 1'b1;
                out_from_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end else if (arrive) begin
            if (!out_valid_reg || take) begin
                out_load       = 1'b1;
                out_valid_next = 1'b1;
            end else begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= out_from_skid ? skid_data_reg : res;
        end
        if (skid_load) begin
            skid_data_reg <= res;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_data_reg};

endmodule

`default_nettype wire

### rtl/core/cpc_checker.sv
// port-level checks on the converter and their bind to the top level
`default_nettype none

module cpc_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [cpc_pkg::M_TDATA_W-1:0] m_tdata
);

    // a stalled word stays and holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // input side is held back only while a word waits on the output
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("s_tready low with no output word");

    // a taken word frees the skid register at once
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && m_tready |=> s_tready)
        else $error("s_tready did not return after a word was taken");

    // ready drops only after an output stall
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("s_tready fell without an output stall");

endmodule

bind cartesian_polar_converter cpc_checker u_cpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/tb.sv
// self-checking testbench of the cordic cartesian/polar converter
`default_nettype none

module tb;

    localparam int PIPE_LATENCY   = 16 + 3;
    localparam int DRAIN_CYCLES   = 3 * PIPE_LATENCY;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam longint RECIP_GAIN = 64'sd2608131496;
    localparam longint DEG90_FX   = 64'sd5898240;
    localparam longint DEG180_FX  = 64'sd11796480;
    localparam longint ANGLE_LIM  = 64'sd23040;
    localparam longint TURN_Q7    = 64'sd46080;

    // atan(2^-i) in degrees, 16 fraction bits
    localparam longint ATAN_STEP [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic [16:0] out_a;
        logic [15:0] out_b;
    } conv_word_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [cpc_pkg::S_TDATA_W-1:0]     s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [cpc_pkg::M_TDATA_W-1:0]     m_tdata;

    conv_word_t pending_conversions [$];
    int         mismatch_count;
    int         quiet_cycles;
    int         send_idle_pct;
    int         recv_idle_pct;

    cartesian_polar_converter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // round to nearest, ties away from zero
    function automatic longint nearest_shift(longint v, int s);
        longint unsigned mag_v;
        longint          q;
        mag_v = (v < 0) ? -v : v;
        q = longint'((mag_v + (64'd1 << (s - 1))) >> s);
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint bound(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // expected output word for one coordinate pair
    function automatic conv_word_t convert_point(logic cmd, logic signed [15:0] in_a,
                                                 logic signed [15:0] in_b);
        longint          x, y, z, dx, dy, res_a, res_b;
        longint unsigned prod;
        conv_word_t      word;
        res_a = 0;
        res_b = 0;
        if (cmd == cpc_pkg::CMD_TO_POLAR) begin
            x = longint'(in_a) * 65536;
            y = longint'(in_b) * 65536;
            z = 0;
            if (in_a != 0 || in_b != 0) begin
                // left half plane: turn by 180 degrees first
                if (x < 0) begin
                    z = (y >= 0) ? DEG180_FX : -DEG180_FX;
                    x = -x;
                    y = -y;
                end
                for (int i = 0; i < 16; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0) begin
                        x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
                    end else begin
                        x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
                    end
                end
                prod  = longint'(x) * RECIP_GAIN;
                res_a = bound(longint'((prod + (64'd1 << 47)) >> 48), 0, 65535);
                res_b = bound(nearest_shift(z, 9), -ANGLE_LIM, ANGLE_LIM);
            end
        end else begin
            // wrap angle by one turn, then fold beyond 90 degrees
            z = in_b;
            if (z > ANGLE_LIM)
                z = z - TURN_Q7;
            else if (z < -ANGLE_LIM)
                z = z + TURN_Q7;
            z = z * 512;
            x = nearest_shift(longint'(in_a) * RECIP_GAIN, 16);
            y = 0;
            if (z > DEG90_FX) begin
                z = z - DEG180_FX; x = -x;
            end else if (z < -DEG90_FX) begin
                z = z + DEG180_FX; x = -x;
            end
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x = x - dx; y = y + dy; z = z - ATAN_STEP[i];
                end else begin
                    x = x + dx; y = y - dy; z = z + ATAN_STEP[i];
                end
            end
            res_a = bound(nearest_shift(x, 16), -32768, 32768);
            res_b = bound(nearest_shift(y, 16), -32768, 32767);
        end
        word.out_a = res_a[16:0];
        word.out_b = res_b[15:0];
        return word;
    endfunction

    // send one word, starting and ending at a falling edge
    task automatic send_point(logic cmd, logic signed [15:0] in_a, logic signed [15:0] in_b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {in_b, in_a};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_conversions.push_back(convert_point(cmd, in_a, in_b));
        @(negedge aclk);
    endtask

    task automatic hold_sender();
        s_tvalid <= 1'b0;
    endtask

    // one random word, biased toward boundaries and small values
    task automatic send_random_point();
        int          pick;
        logic [15:0] ra, rb;
        pick = $urandom_range(0, 99);
        ra   = 16'($urandom);
        rb   = 16'($urandom);
        if (pick < 35) begin
            send_point(cpc_pkg::CMD_TO_POLAR, ra, rb);
        end else if (pick < 45) begin
            send_point(cpc_pkg::CMD_TO_POLAR, 16'($signed($urandom_range(0, 16)) - 8),
                       16'($signed($urandom_range(0, 16)) - 8));
        end else if (pick < 80) begin
            send_point(cpc_pkg::CMD_TO_CART, ra,
                       16'($signed($urandom_range(0, 46080)) - 23040));
        end else if (pick < 90) begin
            send_point(cpc_pkg::CMD_TO_CART, ra, rb);
        end else begin
            // angles close to the quadrant and half-turn edges
            case ($urandom_range(0, 3))
                0: rb = 16'(11520 + $signed($urandom_range(0, 8)) - 4);
                1: rb = 16'(-11520 + $signed($urandom_range(0, 8)) - 4);
                2: rb = 16'(23040 + $signed($urandom_range(0, 8)) - 4);
                default: rb = 16'(-23040 + $signed($urandom_range(0, 8)) - 4);
            endcase
            send_point(cpc_pkg::CMD_TO_CART, $urandom_range(0, 1) ? ra : 16'($urandom_range(0, 64)),
                       rb);
        end
    endtask

    // origin, axes, left half plane and extreme magnitudes
    task automatic test_polar_corners();
        send_point(cpc_pkg::CMD_TO_POLAR, 16'sd0, 16'sd0);
        send_point(cpc_pkg::CMD_TO_POLAR, -16'sd32768, 16'sd0);
        send_point(cpc_pkg::CMD_TO_POLAR, -16'sd1, 16'sd0);
        send_point(cpc_pkg::CMD_TO_POLAR, -16'sd5, -16'sd1);
        send_point(cpc_pkg::CMD_TO_POLAR, 16'sd0, 16'sd32767);
        send_point(cpc_pkg::CMD_TO_POLAR, 16'sd0, -16'sd32768);
        send_point(cpc_pkg::CMD_TO_POLAR, 16'sd32767, 16'sd32767);
        send_point(cpc_pkg::CMD_TO_POLAR, -16'sd32768, -16'sd32768);
        send_point(cpc_pkg::CMD_TO_POLAR, 16'sd32767, 16'sd0);
        send_point(cpc_pkg::CMD_TO_POLAR, 16'sd1, 16'sd1);
    endtask

    // fold past 90 degrees, angle wrap and output clamps
    task automatic test_cartesian_corners();
        send_point(cpc_pkg::CMD_TO_CART, 16'sd32767, 16'sd0);
        send_point(cpc_pkg::CMD_TO_CART, -16'sd32768, 16'sd0);
        send_point(cpc_pkg::CMD_TO_CART, 16'sd32767, 16'sd11520);
        send_point(cpc_pkg::CMD_TO_CART, 16'sd32767, 16'sd11521);
        send_point(cpc_pkg::CMD_TO_CART, 16'sd32767, -16'sd11521);
        send_point(cpc_pkg::CMD_TO_CART, -16'sd32768, -16'sd11520);
        send_point(cpc_pkg::CMD_TO_CART, -16'sd32768, 16'sd23040);
        send_point(cpc_pkg::CMD_TO_CART, -16'sd32768, -16'sd23040);
        send_point(cpc_pkg::CMD_TO_CART, 16'sd1000, 16'sd32767);
        send_point(cpc_pkg::CMD_TO_CART, 16'sd1000, -16'sd32768);
        send_point(cpc_pkg::CMD_TO_CART, 16'sd0, 16'sd5000);
    endtask

    task automatic test_random_mix(int count);
        repeat (count)
            send_random_point();
    endtask

    // sender stops until the pipeline has drained, then resumes
    task automatic test_drain_pause();
        test_random_mix(30);
        hold_sender();
        wait (pending_conversions.size() == 0);
        @(negedge aclk);
        test_random_mix(30);
    endtask

    // receiver readiness
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // result check and watchdog
    always @(posedge aclk) begin
        conv_word_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL cartesian_polar_converter");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            if (pending_conversions.size() == 0) begin
                $error("unexpected word 0x%0h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_conversions.pop_front();
                if (m_tdata[16:0] !== want.out_a) begin
                    $error("out_a expected %0d got %0d", $signed(want.out_a),
                           $signed(m_tdata[16:0]));
                    mismatch_count++;
                end
                if (m_tdata[32:17] !== want.out_b) begin
                    $error("out_b expected %0d got %0d", $signed(want.out_b),
                           $signed(m_tdata[32:17]));
                    mismatch_count++;
                end
                if (m_tdata[cpc_pkg::M_TDATA_W-1:33] !== '0) begin
                    $error("zero fill expected 0 got 0x%0h", m_tdata[cpc_pkg::M_TDATA_W-1:33]);
                    mismatch_count++;
                end
            end
        end
    end

    // reset, then the test sequence
    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = cpc_pkg::CMD_TO_POLAR;
        m_tready       = 1'b0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        send_idle_pct  = 21;
        recv_idle_pct  = 62;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_polar_corners();
        test_cartesian_corners();
        test_random_mix(600);

        send_idle_pct = 62;
        recv_idle_pct = 21;
        test_random_mix(600);
        test_drain_pause();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(540);

        hold_sender();
        wait (pending_conversions.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS cartesian_polar_converter");
        else
            $display("FAIL cartesian_polar_converter");
        $finish;
    end

endmodule

`default_nettype wire
